[sv/piecewise_linear_gain_interp_assert.svh]
// assertion macros for the gain curve rtl
// no dependencies; taken in by `include where assertions are written
`ifndef PIECEWISE_LINEAR_GAIN_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_GAIN_INTERP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLGI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PLGI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/plgi_pkg.sv]
// shared constants and register index codes of the gain curve block
// no dependencies
package plgi_pkg;

    // breakpoints on the curve and segments between them
    localparam int NUM_POINTS   = 4;
    localparam int NUM_SEGMENTS = 3;

    // configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_0 = 3'd0,
        CFG_AXIS_1 = 3'd1,
        CFG_AXIS_2 = 3'd2,
        CFG_AXIS_3 = 3'd3,
        CFG_GAIN_0 = 3'd4,
        CFG_GAIN_1 = 3'd5,
        CFG_GAIN_2 = 3'd6,
        CFG_GAIN_3 = 3'd7
    } t_cfg_idx;

endpackage

[sv/plgi_front.sv]
// segment select stage: finds the segment for a speed, forms offset, spacing and gain step
// depends on plgi_pkg
module plgi_front #(
    parameter int SW = 15,
    parameter int GW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [SW-1:0] i_speed,
    input  logic [SW-1:0] i_axis [plgi_pkg::NUM_POINTS],
    input  logic [GW-1:0] i_gain [plgi_pkg::NUM_POINTS],
    output logic          o_valid,
    input  logic          i_ready,
    output logic [SW-1:0] o_off,
    output logic [SW-1:0] o_span,
    output logic [GW-1:0] o_diff_mag,
    output logic          o_neg,
    output logic [GW-1:0] o_g_lo
);

    logic          r_valid;
    logic [SW-1:0] r_off, r_span;
    logic [GW-1:0] r_diff_mag, r_g_lo;
    logic          r_neg;

    logic          n_found;
    logic          n_bypass;
    logic [SW-1:0] n_a_lo, n_a_hi;
    logic [GW-1:0] n_g_lo, n_g_hi;
    logic [SW-1:0] n_off, n_span;
    logic [GW-1:0] n_diff_mag;
    logic          n_neg;

    // first segment whose upper breakpoint is at or above the speed
    always_comb begin
        n_found  = 1'b0;
        n_bypass = 1'b1;
        n_a_lo   = '0;
        n_a_hi   = '0;
        n_g_lo   = i_gain[plgi_pkg::NUM_POINTS-1];
        n_g_hi   = i_gain[plgi_pkg::NUM_POINTS-1];
        if (i_speed <= i_axis[0]) begin
            n_g_lo = i_gain[0];
            n_g_hi = i_gain[0];
        end else begin
            for (int k = 1; k <= plgi_pkg::NUM_SEGMENTS; k++) begin
                if (!n_found && (i_speed <= i_axis[k])) begin
                    n_found  = 1'b1;
                    n_bypass = 1'b0;
                    n_a_lo   = i_axis[k-1];
                    n_a_hi   = i_axis[k];
                    n_g_lo   = i_gain[k-1];
                    n_g_hi   = i_gain[k];
                end
            end
        end
    end

    // offset, spacing and gain step; a clamped speed gives zero step over unit spacing
    always_comb begin
        if (n_bypass) begin
            n_off      = '0;
            n_span     = SW'(1);
            n_diff_mag = '0;
            n_neg      = 1'b0;
        end else begin
            n_off      = i_speed - n_a_lo;
            n_span     = n_a_hi - n_a_lo;
            n_neg      = n_g_hi < n_g_lo;
            n_diff_mag = n_neg ? (n_g_lo - n_g_hi) : (n_g_hi - n_g_lo);
        end
    end

    assign o_ready = !r_valid || i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_off      <= n_off;
            r_span     <= n_span;
            r_diff_mag <= n_diff_mag;
            r_neg      <= n_neg;
            r_g_lo     <= n_g_lo;
        end
    end

    assign o_valid    = r_valid;
    assign o_off      = r_off;
    assign o_span     = r_span;
    assign o_diff_mag = r_diff_mag;
    assign o_neg      = r_neg;
    assign o_g_lo     = r_g_lo;

endmodule

[sv/plgi_mul.sv]
// multiply stage: gain step magnitude times speed offset
// no package dependency
module plgi_mul #(
    parameter int SW = 15,
    parameter int GW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SW-1:0]    i_off,
    input  logic [SW-1:0]    i_span,
    input  logic [GW-1:0]    i_diff_mag,
    input  logic             i_neg,
    input  logic [GW-1:0]    i_g_lo,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [SW+GW-1:0] o_prod,
    output logic [SW-1:0]    o_span,
    output logic             o_neg,
    output logic [GW-1:0]    o_g_lo
);

    localparam int PW = SW + GW;

    logic          r_valid;
    logic [PW-1:0] r_prod;
    logic [SW-1:0] r_span;
    logic          r_neg;
    logic [GW-1:0] r_g_lo;
    logic [PW-1:0] n_prod;

    // unsigned product, fits since its width is the sum of both operand widths
    assign n_prod  = PW'(i_diff_mag) * PW'(i_off);
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
            r_span <= i_span;
            r_neg  <= i_neg;
            r_g_lo <= i_g_lo;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_span  = r_span;
    assign o_neg   = r_neg;
    assign o_g_lo  = r_g_lo;

endmodule

[sv/plgi_div_cell.sv]
// one restoring division cell: settles quotient bit STEP and passes the item on
// no package dependency
module plgi_div_cell #(
    parameter int SW   = 15,
    parameter int GW   = 16,
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SW+GW-1:0] i_rem,
    input  logic [GW-1:0]    i_quo,
    input  logic [SW-1:0]    i_span,
    input  logic             i_neg,
    input  logic [GW-1:0]    i_g_lo,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [SW+GW-1:0] o_rem,
    output logic [GW-1:0]    o_quo,
    output logic [SW-1:0]    o_span,
    output logic             o_neg,
    output logic [GW-1:0]    o_g_lo
);

    localparam int PW = SW + GW;

    logic          r_valid;
    logic [PW-1:0] r_rem;
    logic [GW-1:0] r_quo;
    logic [SW-1:0] r_span;
    logic          r_neg;
    logic [GW-1:0] r_g_lo;

    logic [PW-1:0] w_trial;
    logic          w_take;
    logic [PW-1:0] n_rem;
    logic [GW-1:0] n_quo;

    // trial subtract of the spacing shifted to this bit
    assign w_trial = PW'(i_span) << STEP;
    assign w_take  = i_rem >= w_trial;
    assign n_rem   = w_take ? (i_rem - w_trial) : i_rem;
    assign n_quo   = i_quo | (w_take ? (GW'(1) << STEP) : GW'(0));
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_span <= i_span;
            r_neg  <= i_neg;
            r_g_lo <= i_g_lo;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_span  = r_span;
    assign o_neg   = r_neg;
    assign o_g_lo  = r_g_lo;

endmodule

[sv/piecewise_linear_gain_interp.sv]
// Four-breakpoint gain curve. Speed items enter on the s_ channel, one gain
// item per speed leaves on the m_ channel, in order.
// The user must write breakpoints and gains on the i_cfg_ port only while idle
// (not enforced); indexes 0 to 3 are the speed breakpoints, 4 to 7 the Q2.14 gains.
// Pipeline: a segment select stage, a multiply stage, one division cell per
// gain bit (16 at default widths) and an output register, each registered.
// Throughput is one item per cycle while m_tready stays high; every stage
// holds its own item and hands it to the next stage, so the division chain
// sets the latency and not the rate.
// When m_tready is low the output register holds its item; upstream stages
// keep filling empty slots, and s_tready drops only once every stage is full.
// Synchronous reset empties all stages and restores breakpoints 1000, 3000,
// 5000, 7000 rpm and gains of 1.0.
// Depends on plgi_pkg, plgi_front, plgi_mul, plgi_div_cell and the assertion header.
`include "piecewise_linear_gain_interp_assert.svh"

module piecewise_linear_gain_interp #(
    parameter int SPEED_WIDTH    = 15,
    parameter int GAIN_FRAC_BITS = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // speed (bits SPEED_WIDTH-1:0), zero padded to whole bytes
    input  logic [((SPEED_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // gain (bits GAIN_FRAC_BITS+1:0), zero padded to whole bytes
    output logic [((GAIN_FRAC_BITS+2+7)/8)*8-1:0] m_tdata,
    input  logic                                  i_cfg_we,
    input  logic [plgi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [((GAIN_FRAC_BITS+2 > SPEED_WIDTH) ?
                   GAIN_FRAC_BITS+2 : SPEED_WIDTH)-1:0] i_cfg_wdata
);

    localparam int SW  = SPEED_WIDTH;
    localparam int GW  = GAIN_FRAC_BITS + 2;
    localparam int PW  = SW + GW;
    localparam int MTW = ((GW + 7) / 8) * 8;
    localparam int NP  = plgi_pkg::NUM_POINTS;

    // configuration registers
    logic [SW-1:0] r_axis [NP];
    logic [GW-1:0] r_gain [NP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis[0] <= SW'(1000);
            r_axis[1] <= SW'(3000);
            r_axis[2] <= SW'(5000);
            r_axis[3] <= SW'(7000);
            for (int p = 0; p < NP; p++) begin
                r_gain[p] <= GW'(1) << GAIN_FRAC_BITS;
            end
        end else if (i_cfg_we) begin
            case (plgi_pkg::t_cfg_idx'(i_cfg_idx))
                plgi_pkg::CFG_AXIS_0: r_axis[0] <= i_cfg_wdata[SW-1:0];
                plgi_pkg::CFG_AXIS_1: r_axis[1] <= i_cfg_wdata[SW-1:0];
                plgi_pkg::CFG_AXIS_2: r_axis[2] <= i_cfg_wdata[SW-1:0];
                plgi_pkg::CFG_AXIS_3: r_axis[3] <= i_cfg_wdata[SW-1:0];
                plgi_pkg::CFG_GAIN_0: r_gain[0] <= i_cfg_wdata[GW-1:0];
                plgi_pkg::CFG_GAIN_1: r_gain[1] <= i_cfg_wdata[GW-1:0];
                plgi_pkg::CFG_GAIN_2: r_gain[2] <= i_cfg_wdata[GW-1:0];
                plgi_pkg::CFG_GAIN_3: r_gain[3] <= i_cfg_wdata[GW-1:0];
                default: ;
            endcase
        end
    end

    // segment select
    logic          f_valid, f_ready;
    logic [SW-1:0] f_off, f_span;
    logic [GW-1:0] f_diff_mag, f_g_lo;
    logic          f_neg;

    plgi_front #(.SW(SW), .GW(GW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_speed    (s_tdata[SW-1:0]),
        .i_axis     (r_axis),
        .i_gain     (r_gain),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_off      (f_off),
        .o_span     (f_span),
        .o_diff_mag (f_diff_mag),
        .o_neg      (f_neg),
        .o_g_lo     (f_g_lo)
    );

    // division chain links, slot 0 is the multiply stage output
    logic          c_valid [GW+1];
    logic          c_ready [GW+1];
    logic [PW-1:0] c_rem   [GW+1];
    logic [GW-1:0] c_quo   [GW+1];
    logic [SW-1:0] c_span  [GW+1];
    logic          c_neg   [GW+1];
    logic [GW-1:0] c_g_lo  [GW+1];

    plgi_mul #(.SW(SW), .GW(GW)) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .o_ready    (f_ready),
        .i_off      (f_off),
        .i_span     (f_span),
        .i_diff_mag (f_diff_mag),
        .i_neg      (f_neg),
        .i_g_lo     (f_g_lo),
        .o_valid    (c_valid[0]),
        .i_ready    (c_ready[0]),
        .o_prod     (c_rem[0]),
        .o_span     (c_span[0]),
        .o_neg      (c_neg[0]),
        .o_g_lo     (c_g_lo[0])
    );

    assign c_quo[0] = '0;

    // one cell per quotient bit, most significant first
    for (genvar j = 0; j < GW; j++) begin : g_div
        plgi_div_cell #(.SW(SW), .GW(GW), .STEP(GW - 1 - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[j]),
            .o_ready (c_ready[j]),
            .i_rem   (c_rem[j]),
            .i_quo   (c_quo[j]),
            .i_span  (c_span[j]),
            .i_neg   (c_neg[j]),
            .i_g_lo  (c_g_lo[j]),
            .o_valid (c_valid[j+1]),
            .i_ready (c_ready[j+1]),
            .o_rem   (c_rem[j+1]),
            .o_quo   (c_quo[j+1]),
            .o_span  (c_span[j+1]),
            .o_neg   (c_neg[j+1]),
            .o_g_lo  (c_g_lo[j+1])
        );
    end

    // output register: lower gain plus the signed quotient
    logic          r_out_valid;
    logic [GW-1:0] r_out_gain;
    logic [GW-1:0] n_out_gain;
    logic          w_out_rdy;

    assign n_out_gain = c_neg[GW] ? (c_g_lo[GW] - c_quo[GW]) : (c_g_lo[GW] + c_quo[GW]);
    assign w_out_rdy  = !r_out_valid || m_tready;
    assign c_ready[GW] = w_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_valid <= c_valid[GW];
        end
        if (w_out_rdy && c_valid[GW]) begin
            r_out_gain <= n_out_gain;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = MTW'(r_out_gain);

    // input side stalls only behind a waiting result
    `PLGI_ASSERT_IMPL(a_stall_from_out, i_clk, i_rst_n, !s_tready, m_tvalid,
        "input stalled with no result waiting")
    // an item leaving the last cell lands in the output register
    `PLGI_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, c_valid[GW] && w_out_rdy, m_tvalid,
        "item from division chain lost")
    // a taken result with nothing behind it empties the output register
    `PLGI_ASSERT_NEXT(a_out_drain, i_clk, i_rst_n,
        m_tvalid && m_tready && !c_valid[GW], !m_tvalid,
        "result repeated after hand-off")

endmodule
